// ===== rtl/core/isu_pkg.sv =====
// ----------------------------------------------------------------------------
// isu_pkg: shared types and constants of the insertion sorter
// Capacity, counter width, beat payload structs and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package isu_pkg;

  // store capacity and width of the fill counter (holds 0..MAX_LEN)
  localparam int MAX_LEN = 16;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  // input beat
  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               overflow;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic ins;     // insert the input value
    logic shift;   // pop head entry, move store down by one
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic one_left;  // exactly one entry remains
  } dp_stat_t;

endpackage

// ===== rtl/core/isu_datapath.sv =====
// ----------------------------------------------------------------------------
// isu_datapath: sorted store of the insertion sorter
// Row of compare/shift cells that inserts one value per cycle in order, plus
// the fill counter and drop flag. Output pops the head and shifts down.
// ----------------------------------------------------------------------------
module isu_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  isu_pkg::dp_cmd_t  cmd,
  input  logic signed [31:0] in_value,
  output isu_pkg::dp_stat_t stat,
  output isu_pkg::out_item_t out_data
);
  import isu_pkg::*;

  logic signed [31:0] store_r [MAX_LEN];
  logic signed [31:0] store_nxt [MAX_LEN];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               drop_r, drop_nxt;
  logic [MAX_LEN-1:0] gt;
  logic               full;

  assign full = (count_r == CNT_W'(MAX_LEN));

  // per cell: entry moves up (or is free) when it lies above the new value
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      gt[i] = (CNT_W'(i) >= count_r) || (store_r[i] > in_value);
    end
  end

  // next store contents
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      store_nxt[i] = store_r[i];
    end
    if (cmd.ins && !full) begin
      store_nxt[0] = gt[0] ? in_value : store_r[0];
      for (int i = 1; i < MAX_LEN; i++) begin
        if (gt[i]) begin
          store_nxt[i] = gt[i-1] ? store_r[i-1] : in_value;
        end
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < MAX_LEN - 1; i++) begin
        store_nxt[i] = store_r[i+1];
      end
    end
  end

  // fill count and drop flag
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (cmd.ins) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (cmd.shift) begin
      count_nxt = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // store payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LEN; i++) begin
      store_r[i] <= store_nxt[i];
    end
  end

  assign stat.one_left       = (count_r == CNT_W'(1));
  assign out_data.sorted_value = store_r[0];
  assign out_data.final_res    = (count_r == CNT_W'(1));
  assign out_data.overflow     = drop_r;

endmodule

// ===== rtl/core/isu_ctrl.sv =====
// ----------------------------------------------------------------------------
// isu_ctrl: controller of the insertion sorter
// Accepts beats while idle, and after a last beat drains the store one
// result per cycle until the greatest entry has gone out.
// ----------------------------------------------------------------------------
module isu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_last,
  input  isu_pkg::dp_stat_t stat,
  output isu_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);
  import isu_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign accept = start && (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.one_left) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.ins   = accept;
  assign cmd.shift = (state_r == ST_EMIT);
  assign busy      = (state_r == ST_EMIT);
  assign out_valid = (state_r == ST_EMIT);

endmodule

// ===== rtl/core/insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_unit: streaming insertion sorter, top level
// A beat is inserted in the cycle it is accepted; after a last beat the stored
// values follow back to back in ascending order, starting in the next cycle.
// Takes one beat per cycle while idle; busy while the stored values go out
// through the single shift-out path of the store. Results cannot be stalled.
// Reset (synchronous, rst_n low) clears fill count, drop flag and state.
// ----------------------------------------------------------------------------
module insertion_sorter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  isu_pkg::in_item_t  in_data,
  output logic               out_valid,
  output isu_pkg::out_item_t out_data
);
  import isu_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  isu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_last   (in_data.last),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // sorted store
  isu_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_value (in_data.value),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/isu_checker.sv =====
// ----------------------------------------------------------------------------
// isu_port_checks: port-level checks of the insertion sorter
// Watches the beat handshake and the shape of each output run.
// ----------------------------------------------------------------------------
module isu_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input isu_pkg::in_item_t  in_data,
  input logic               out_valid,
  input isu_pkg::out_item_t out_data
);
  import isu_pkg::*;

  // a beat that is not last produces no result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_data.last |=> !out_valid && !busy)
    else $error("result after non-last beat");

  // a last beat opens an output run in the next cycle
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.last |=> out_valid && busy)
    else $error("no output after last beat");

  // a run continues until its final result
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_res |=> out_valid)
    else $error("output run ended early");

  // the run ends right after its final result
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.final_res |=> !out_valid)
    else $error("output after final result");

  // overflow is constant and values never descend within a run
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && $past(rst_n) |->
      (out_data.overflow == $past(out_data.overflow)) &&
      (out_data.sorted_value >= $past(out_data.sorted_value)))
    else $error("run not ascending or overflow changed");

endmodule

bind insertion_sorter_unit isu_port_checks u_isu_port_checks (.*);
